[rtl/etm_pkg.sv]
`default_nettype none
package etm_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS = 16;
   localparam int CORDIC_STEPS = 30;
   localparam int NUM_ROWS = 4;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [FRAC_BITS+1:0] ONE_FX = (FRAC_BITS+2)'(1) <<< FRAC_BITS;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [15:0] angle_x;
      logic [15:0] angle_y;
      logic [15:0] angle_z;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
   } req_type;

   typedef struct packed {
      logic [1:0] row_index;
      logic signed [31:0] col0;
      logic signed [31:0] col1;
      logic signed [31:0] col2;
      logic signed [31:0] col3;
      logic last_row;
   } rsp_type;

   // Arctangent of 2^-i as a fraction of a turn, scaled by 2^32.
   function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
      logic signed [33:0] r;
      begin
         case (i)
            5'd0: r = 34'h020000000;  5'd1: r = 34'h012E4051D;
            5'd2: r = 34'h009FB385B;  5'd3: r = 34'h0051111D4;
            5'd4: r = 34'h0028B0D43;  5'd5: r = 34'h00145D7E1;
            5'd6: r = 34'h000A2F61E;  5'd7: r = 34'h000517C55;
            5'd8: r = 34'h00028BE53;  5'd9: r = 34'h000145F2E;
            5'd10: r = 34'h0000A2F98; 5'd11: r = 34'h0000517CC;
            5'd12: r = 34'h000028BE6; 5'd13: r = 34'h0000145F3;
            5'd14: r = 34'h00000A2F9; 5'd15: r = 34'h00000517C;
            5'd16: r = 34'h0000028BE; 5'd17: r = 34'h00000145F;
            5'd18: r = 34'h000000A2F; 5'd19: r = 34'h000000517;
            5'd20: r = 34'h00000028B; 5'd21: r = 34'h000000145;
            5'd22: r = 34'h0000000A2; 5'd23: r = 34'h000000051;
            5'd24: r = 34'h000000028; 5'd25: r = 34'h000000014;
            5'd26: r = 34'h00000000A; 5'd27: r = 34'h000000005;
            5'd28: r = 34'h000000002; 5'd29: r = 34'h000000001;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // Rounded fixed-point product, half up, with arithmetic shift.
   function automatic logic signed [33:0] fx_round(input logic signed [65:0] p);
      logic signed [65:0] t;
      begin
         t = (p + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         return t[33:0];
      end
   endfunction

   function automatic logic signed [33:0] fx_clamp(input logic signed [33:0] v);
      begin
         if (v > 34'(ONE_FX)) return 34'(ONE_FX);
         else if (v < -34'(ONE_FX)) return -34'(ONE_FX);
         else return v;
      end
   endfunction

endpackage
`default_nettype wire

[rtl/etm_cordic.sv]
`default_nettype none
// Pipelined CORDIC: one micro-rotation per stage, new angle every cycle.
module etm_cordic (
   input  wire logic clock,
   input  wire logic [15:0] angle,
   output logic signed [33:0] cos_out,
   output logic signed [33:0] sin_out
);
   localparam int N = etm_pkg::CORDIC_STEPS;
   logic signed [33:0] x_ff [0:N];
   logic signed [33:0] y_ff [0:N];
   logic signed [33:0] z_ff [0:N];
   logic [1:0] q_ff [0:N];
   logic signed [33:0] c_w, s_w, cr, sr;
   logic signed [33:0] cos_ff, sin_ff;
   logic [31:0] phase;

   assign phase = {angle[etm_pkg::ANGLE_BITS-1:0], (32 - etm_pkg::ANGLE_BITS)'(0)};

   // Input stage.
   always_ff @(posedge clock) begin
      x_ff[0] <= etm_pkg::CORDIC_GAIN;
      y_ff[0] <= '0;
      z_ff[0] <= {4'b0, phase[29:0]};
      q_ff[0] <= phase[31:30];
   end

   // Rotation stages.
   for (genvar i = 0; i < N; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (!z_ff[i][33]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - etm_pkg::atan_turn(5'(i));
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + etm_pkg::atan_turn(5'(i));
         end
         q_ff[i+1] <= q_ff[i];
      end
   end

   // Round to the fraction width, clamp, and apply the quadrant.
   always_comb begin
      cr = etm_pkg::fx_clamp((x_ff[N] + (34'sd1 <<< (29 - etm_pkg::FRAC_BITS)))
                             >>> (30 - etm_pkg::FRAC_BITS));
      sr = etm_pkg::fx_clamp((y_ff[N] + (34'sd1 <<< (29 - etm_pkg::FRAC_BITS)))
                             >>> (30 - etm_pkg::FRAC_BITS));
      case (q_ff[N])
         2'd0: begin c_w = cr; s_w = sr; end
         2'd1: begin c_w = -sr; s_w = cr; end
         2'd2: begin c_w = -cr; s_w = -sr; end
         default: begin c_w = sr; s_w = -cr; end
      endcase
   end

   always_ff @(posedge clock) begin
      cos_ff <= c_w;
      sin_ff <= s_w;
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
endmodule
`default_nettype wire

[rtl/etm_lane.sv]
`default_nettype none
// One matrix-row lane: rotation row entries from sines and cosines, then scaling.
module etm_lane (
   input  wire logic clock,
   input  wire logic [1:0] row_sel,
   input  wire logic signed [33:0] cx, sx, cy, sy, cz, sz,
   input  wire logic signed [31:0] scale,
   output logic signed [31:0] e0, e1, e2
);
   logic signed [33:0] a_ff, b_ff, cz_ff, sz_ff, sy_ff, sxcy_ff, cxcy_ff;
   logic signed [33:0] cxcz_ff, cxsz_ff, sxsz_ff, sxcz_ff;
   logic signed [33:0] p0_ff, p1_ff, r2_ff, q0_ff, q1_ff;
   logic signed [33:0] r0_ff, r1_ff, r2b_ff;
   logic signed [31:0] sc1_ff, sc2_ff, sc3_ff;
   logic signed [31:0] e0_ff, e1_ff, e2_ff;

   function automatic logic signed [31:0] scl(input logic signed [31:0] s,
                                              input logic signed [33:0] e);
      logic signed [33:0] t;
      begin
         t = etm_pkg::fx_round(66'(s) * 66'(etm_pkg::fx_clamp(e)));
         if (t > 34'sh07FFFFFFF) return 32'sh7FFFFFFF;
         else if (t < -34'sh080000000) return 32'sh80000000;
         else return t[31:0];
      end
   endfunction

   // Stage 1: the lane's leading factor (cy for row 0, sx*sy or cx*sy below).
   always_ff @(posedge clock) begin
      case (row_sel)
         2'd0: a_ff <= cy;
         2'd1: a_ff <= etm_pkg::fx_round(66'(sx) * 66'(sy));
         default: a_ff <= etm_pkg::fx_round(66'(cx) * 66'(sy));
      endcase
      b_ff <= '0;
      cz_ff <= cz; sz_ff <= sz; sy_ff <= sy;
      sxcy_ff <= etm_pkg::fx_round(66'(sx) * 66'(cy));
      cxcy_ff <= etm_pkg::fx_round(66'(cx) * 66'(cy));
      cxcz_ff <= etm_pkg::fx_round(66'(cx) * 66'(cz));
      cxsz_ff <= etm_pkg::fx_round(66'(cx) * 66'(sz));
      sxsz_ff <= etm_pkg::fx_round(66'(sx) * 66'(sz));
      sxcz_ff <= etm_pkg::fx_round(66'(sx) * 66'(cz));
      sc1_ff <= scale;
   end

   // Stage 2: products with the z terms.
   always_ff @(posedge clock) begin
      p0_ff <= etm_pkg::fx_round(66'(a_ff) * 66'(cz_ff));
      p1_ff <= etm_pkg::fx_round(66'(a_ff) * 66'(sz_ff));
      case (row_sel)
         2'd0: begin q0_ff <= b_ff; q1_ff <= b_ff; r2_ff <= sy_ff; end
         2'd1: begin q0_ff <= -cxsz_ff; q1_ff <= cxcz_ff; r2_ff <= sxcy_ff; end
         default: begin q0_ff <= sxsz_ff; q1_ff <= -sxcz_ff; r2_ff <= cxcy_ff; end
      endcase
      sc2_ff <= sc1_ff;
   end

   // Stage 3: sum the terms of each rotation entry.
   always_ff @(posedge clock) begin
      if (row_sel == 2'd0) begin
         r0_ff <= p0_ff;
         r1_ff <= p1_ff;
      end else begin
         r0_ff <= q0_ff - p0_ff;
         r1_ff <= q1_ff - p1_ff;
      end
      r2b_ff <= r2_ff;
      sc3_ff <= sc2_ff;
   end

   // Stage 4: scale.
   always_ff @(posedge clock) begin
      e0_ff <= scl(sc3_ff, r0_ff);
      e1_ff <= scl(sc3_ff, r1_ff);
      e2_ff <= scl(sc3_ff, r2b_ff);
   end

   assign e0 = e0_ff;
   assign e1 = e1_ff;
   assign e2 = e2_ff;
endmodule
`default_nettype wire

[rtl/euler_transform_matrix.sv]
`default_nettype none
// Euler-angle model matrix, row-vector convention: M = S * Rx * Ry * Rz * T.
// Request channel: drive req with a transform and raise start; it is taken
// at a clock edge where start is high and busy is low.
// Response channel: four rows leave on consecutive cycles, each marked by
// rsp_valid for one cycle, rows 0..3 in order, rsp.last_row on row 3.
// Pipeline: the first row reaches the response ports through 37 register
// stages (31 in the CORDIC pipeline, output rounding, four lane stages,
// merge register), then one row per cycle.
// Pacing: busy rises after each accepted request and stays high until the
// hold counter reaches zero, a spacing set by the single row output port.
// Three row lanes work side by side; the merge stage serializes their rows
// with the position row.
// Reset clears all valid and counter state; payload registers are not reset.
// The receiver cannot stall: every row must be taken when it is shown.
module euler_transform_matrix (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire etm_pkg::req_type req,
   output logic rsp_valid,
   output etm_pkg::rsp_type rsp
);
   localparam int LAT = etm_pkg::CORDIC_STEPS + 2 + 4;

   logic [1:0] hold_ff, hold_in;
   logic accept;
   logic [LAT-1:0] vld_ff;
   logic signed [31:0] sx_ff [0:LAT-1];
   logic signed [31:0] sy_ff [0:LAT-1];
   logic signed [31:0] sz_ff [0:LAT-1];
   logic signed [31:0] px_ff [0:LAT-1];
   logic signed [31:0] py_ff [0:LAT-1];
   logic signed [31:0] pz_ff [0:LAT-1];
   logic signed [33:0] cx, snx, cy, sny, cz, snz;
   logic signed [31:0] l_e [0:2][0:2];
   logic signed [31:0] m_ff [0:3][0:2];
   logic [1:0] row_ff, row_in;
   logic out_ff, out_in;

   assign accept = start && !busy;
   assign busy = (hold_ff != 2'd0);

   // Request pacing: the hold counter is loaded on accept and counts down to zero.
   always_comb begin
      hold_in = hold_ff;
      if (accept) hold_in = 2'd3;
      else if (hold_ff != 2'd0) hold_in = hold_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
         vld_ff <= '0;
      end else begin
         hold_ff <= hold_in;
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // Delay line carrying scale and position alongside the sine pipeline.
   always_ff @(posedge clock) begin
      sx_ff[0] <= req.scale_x; sy_ff[0] <= req.scale_y; sz_ff[0] <= req.scale_z;
      px_ff[0] <= req.pos_x; py_ff[0] <= req.pos_y; pz_ff[0] <= req.pos_z;
      for (int i = 1; i < LAT; i++) begin
         sx_ff[i] <= sx_ff[i-1]; sy_ff[i] <= sy_ff[i-1]; sz_ff[i] <= sz_ff[i-1];
         px_ff[i] <= px_ff[i-1]; py_ff[i] <= py_ff[i-1]; pz_ff[i] <= pz_ff[i-1];
      end
   end

   etm_cordic u_cx (.clock(clock), .angle(req.angle_x), .cos_out(cx), .sin_out(snx));
   etm_cordic u_cy (.clock(clock), .angle(req.angle_y), .cos_out(cy), .sin_out(sny));
   etm_cordic u_cz (.clock(clock), .angle(req.angle_z), .cos_out(cz), .sin_out(snz));

   // Three row lanes; the scale enters at the lanes' input stage.
   etm_lane u_l0 (.clock(clock), .row_sel(2'd0), .cx(cx), .sx(snx), .cy(cy),
                  .sy(sny), .cz(cz), .sz(snz), .scale(sx_ff[LAT-5]),
                  .e0(l_e[0][0]), .e1(l_e[0][1]), .e2(l_e[0][2]));
   etm_lane u_l1 (.clock(clock), .row_sel(2'd1), .cx(cx), .sx(snx), .cy(cy),
                  .sy(sny), .cz(cz), .sz(snz), .scale(sy_ff[LAT-5]),
                  .e0(l_e[1][0]), .e1(l_e[1][1]), .e2(l_e[1][2]));
   etm_lane u_l2 (.clock(clock), .row_sel(2'd2), .cx(cx), .sx(snx), .cy(cy),
                  .sy(sny), .cz(cz), .sz(snz), .scale(sz_ff[LAT-5]),
                  .e0(l_e[2][0]), .e1(l_e[2][1]), .e2(l_e[2][2]));

   // Merge stage: capture all rows, then send one per cycle.
   always_comb begin
      row_in = row_ff;
      out_in = out_ff;
      if (vld_ff[LAT-1]) begin
         row_in = 2'd0;
         out_in = 1'b1;
      end else if (out_ff) begin
         row_in = row_ff + 2'd1;
         out_in = (row_ff != 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         out_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
         out_ff <= out_in && !(out_ff && row_ff == 2'd3 && !vld_ff[LAT-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (vld_ff[LAT-1]) begin
         for (int r = 0; r < 3; r++)
            for (int j = 0; j < 3; j++)
               m_ff[r][j] <= l_e[r][j];
         m_ff[3][0] <= px_ff[LAT-1];
         m_ff[3][1] <= py_ff[LAT-1];
         m_ff[3][2] <= pz_ff[LAT-1];
      end
   end

   assign rsp_valid = out_ff;
   assign rsp.row_index = row_ff;
   assign rsp.col0 = m_ff[row_ff][0];
   assign rsp.col1 = m_ff[row_ff][1];
   assign rsp.col2 = m_ff[row_ff][2];
   assign rsp.col3 = (row_ff == 2'd3) ? 32'(etm_pkg::ONE_FX) : 32'sd0;
   assign rsp.last_row = (row_ff == 2'd3);

   // Each row group starts with row 0 once the pipeline's last valid bit is set.
   a_start_row0: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-1] |=> (rsp_valid && row_ff == 2'd0)) else $error("bad row start");
   // Rows advance in order while output is active.
   a_row_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && row_ff != 2'd3) |=> (rsp_valid && row_ff == $past(row_ff) + 2'd1))
      else $error("row sequence broken");
   // Request spacing raises busy after each accepted request.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("busy missing after request");
endmodule
`default_nettype wire

[tb/sv/euler_transform_matrix_tb.sv]
`timescale 1ns / 100ps
`default_nettype none

module euler_transform_matrix_tb;
   import etm_pkg::*;

   typedef longint signed fx_t;

   localparam fx_t UNIT = fx_t'(1) << FRAC_BITS;
   localparam int TOTAL_RANDOM = 220;
   localparam int DRAIN_CYCLES = 60;

   // Arctangent table of the rotation stages, turn fraction times 2^32.
   localparam fx_t ARC_TURN [0:29] = '{
      64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
      64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001};

   // Floor shift of a signed value.
   function automatic fx_t floor_shift(input fx_t v, input int s);
      return v >>> s;
   endfunction

   function automatic fx_t limit(input fx_t v, input fx_t lo, input fx_t hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Fixed-point product rounded half up.
   function automatic fx_t fx_product(input fx_t a, input fx_t b);
      return floor_shift(a * b + (fx_t'(1) << (FRAC_BITS - 1)), FRAC_BITS);
   endfunction

   // Sine and cosine of a binary angle by shift-and-add rotation.
   task automatic sin_cos(input logic [15:0] angle, output fx_t cs, output fx_t sn);
      logic [31:0] phase;
      fx_t x, y, z, dx, dy, c, s;
      begin
         phase = {angle, 16'h0};
         z = fx_t'(phase[29:0]);
         x = 652032874;
         y = 0;
         for (int i = 0; i < 30; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
               x -= dx; y += dy; z -= ARC_TURN[i];
            end else begin
               x += dx; y -= dy; z += ARC_TURN[i];
            end
         end
         c = limit(floor_shift(x + (fx_t'(1) << (29 - FRAC_BITS)), 30 - FRAC_BITS),
                   -UNIT, UNIT);
         s = limit(floor_shift(y + (fx_t'(1) << (29 - FRAC_BITS)), 30 - FRAC_BITS),
                   -UNIT, UNIT);
         case (phase[31:30])
            2'd0: begin cs = c; sn = s; end
            2'd1: begin cs = -s; sn = c; end
            2'd2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
         endcase
      end
   endtask

   // Scoreboard of expected matrix rows.
   class matrix_scoreboard;
      rsp_type pending_rows[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      task note_transform(input req_type t);
         fx_t cx, sx, cy, sy, cz, sz, sxsy, cxsy;
         fx_t rot [3][3];
         fx_t scl [3];
         fx_t e;
         rsp_type row;
         begin
            sin_cos(t.angle_x, cx, sx);
            sin_cos(t.angle_y, cy, sy);
            sin_cos(t.angle_z, cz, sz);
            sxsy = fx_product(sx, sy);
            cxsy = fx_product(cx, sy);
            rot[0][0] = fx_product(cy, cz);
            rot[0][1] = fx_product(cy, sz);
            rot[0][2] = sy;
            rot[1][0] = -fx_product(sxsy, cz) - fx_product(cx, sz);
            rot[1][1] = -fx_product(sxsy, sz) + fx_product(cx, cz);
            rot[1][2] = fx_product(sx, cy);
            rot[2][0] = -fx_product(cxsy, cz) + fx_product(sx, sz);
            rot[2][1] = -fx_product(cxsy, sz) - fx_product(sx, cz);
            rot[2][2] = fx_product(cx, cy);
            scl[0] = fx_t'(t.scale_x);
            scl[1] = fx_t'(t.scale_y);
            scl[2] = fx_t'(t.scale_z);
            for (int r = 0; r < 3; r++) begin
               fx_t ent [3];
               for (int j = 0; j < 3; j++) begin
                  e = limit(rot[r][j], -UNIT, UNIT);
                  ent[j] = limit(fx_product(scl[r], e), -64'sd2147483648, 64'sd2147483647);
               end
               row.row_index = 2'(r);
               row.col0 = ent[0][31:0];
               row.col1 = ent[1][31:0];
               row.col2 = ent[2][31:0];
               row.col3 = '0;
               row.last_row = 1'b0;
               pending_rows.push_back(row);
            end
            row.row_index = 2'd3;
            row.col0 = t.pos_x;
            row.col1 = t.pos_y;
            row.col2 = t.pos_z;
            row.col3 = 32'(UNIT);
            row.last_row = 1'b1;
            pending_rows.push_back(row);
         end
      endtask

      function void check_row(input rsp_type got);
         rsp_type want;
         if (pending_rows.size() == 0) begin
            $display("%0t: unexpected row, actual %p", $time, got);
            errors++;
            return;
         end
         want = pending_rows.pop_front();
         if (got.row_index !== want.row_index || got.col0 !== want.col0 ||
             got.col1 !== want.col1 || got.col2 !== want.col2 ||
             got.col3 !== want.col3 || got.last_row !== want.last_row) begin
            $display("%0t: row mismatch, expected %p, actual %p", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req = '0;
   logic rsp_valid;
   rsp_type rsp;

   matrix_scoreboard board = new();

   euler_transform_matrix dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   always #5 clock = ~clock;

   // Requests are noted when accepted; rows are checked when strobed.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_transform(req);
         if (rsp_valid) board.check_row(rsp);
      end
   end

   // Sends one request, with a random gap before it unless told not to.
   task automatic send_transform(input req_type t, input bit no_gap);
      int gap;
      begin
         gap = no_gap ? 0 : $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req <= t;
         start <= 1'b1;
         @(posedge clock);
         while (busy) @(posedge clock);
         @(negedge clock);
      end
   endtask

   function automatic logic [31:0] rand_length();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(UNIT);
         3: return -32'(UNIT);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(0, 3)) << 14;
         1: return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 3) - 1);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_transform();
      req_type t;
      t.pos_x = $urandom; t.pos_y = $urandom; t.pos_z = $urandom;
      t.angle_x = rand_angle(); t.angle_y = rand_angle(); t.angle_z = rand_angle();
      t.scale_x = rand_length(); t.scale_y = rand_length(); t.scale_z = rand_length();
      return t;
   endfunction

   task automatic wait_drained();
      begin
         start <= 1'b0;
         while (board.pending_rows.size() != 0) @(negedge clock);
      end
   endtask

   // Main stimulus: directed corners, then random transforms.
   initial begin
      req_type t;
      logic [15:0] corner_angles [6] = '{16'h0000, 16'h4000, 16'h8000,
                                         16'hC000, 16'hFFFF, 16'h2000};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Quadrant and other corner angles, extreme positions, and unit scales of either sign.
      for (int k = 0; k < 6; k++) begin
         t.pos_x = 32'h8000_0000; t.pos_y = 32'h7FFF_FFFF; t.pos_z = '0;
         t.angle_x = corner_angles[k];
         t.angle_y = corner_angles[(k + 1) % 6];
         t.angle_z = corner_angles[(k + 2) % 6];
         t.scale_x = 32'(UNIT); t.scale_y = -32'(UNIT); t.scale_z = 32'(UNIT);
         send_transform(t, k < 3);
      end
      // Most negative scale against a rotation entry of minus one saturates.
      for (int k = 0; k < 4; k++) begin
         t.pos_x = '1; t.pos_y = '0; t.pos_z = 32'h7FFF_FFFF;
         t.angle_x = 16'h8000; t.angle_y = 16'(k << 14); t.angle_z = 16'h8000;
         t.scale_x = 32'h8000_0000; t.scale_y = 32'h8000_0000;
         t.scale_z = (k[0]) ? 32'h7FFF_FFFF : 32'h0;
         send_transform(t, 1'b0);
      end
      // Pause until all rows are out, then send again.
      wait_drained();
      for (int k = 0; k < 6; k++) send_transform(random_transform(), 1'b1);

      for (int n = 0; n < TOTAL_RANDOM; n++) begin
         if (n == TOTAL_RANDOM / 2) wait_drained();
         send_transform(random_transform(), n % 40 < 10);
      end
      start <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending_rows.size() == 0)
         $display("euler_transform_matrix_tb: PASS");
      else
         $display("euler_transform_matrix_tb: FAIL");
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("euler_transform_matrix_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
